### rtl/core/rfb_pkg.sv
// shared types and constants of the rs485 frame builder
package rfb_pkg;

  // header bytes carried by a start item, length byte included
  localparam int unsigned HDR_BYTES = 6;
  // added to the payload length to give the frame length
  localparam logic [7:0] FRAME_OVERHEAD = 8'd8;
  // frame length is payload length plus overhead, up to 263
  localparam int unsigned FLEN_W = 9;
  // frame length limit default
  localparam int unsigned MAX_FRAME_BYTES_DEF = 208;
  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_NO_FRAME = 2'd2
  } status_e;

  // one classified operation for the back end
  typedef struct packed {
    logic                       restart;  // begin a new crc before this op
    logic                       is_err;   // single error result
    status_e                    status;
    logic [2:0]                 n_data;   // data bytes in this op
    logic                       add_crc;  // append crc after the data bytes
    logic [HDR_BYTES-1:0][7:0]  bytes;    // data bytes, first in slot 0
  } entry_t;

  // push side of the queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### rtl/core/rfb_front.sv
// front end: accepts items, tracks the open frame and classifies each item
module rfb_front #(
  parameter int unsigned MAX_FRAME_BYTES = rfb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [7:0]            start_marker_i,
  input  logic [7:0]            address_one_i,
  input  logic [7:0]            address_two_i,
  input  logic [7:0]            frame_command_i,
  input  logic [7:0]            frame_subcommand_i,
  input  logic [7:0]            payload_length_i,
  input  logic [7:0]            payload_byte_i,
  input  rfb_pkg::qstat_t       qstat_i,
  output rfb_pkg::push_t        push_o
);

  logic                      open_q, open_d;
  logic [7:0]                remain_q, remain_d;
  logic                      accept;
  logic [rfb_pkg::FLEN_W-1:0] flen;
  logic                      too_long;
  logic [7:0]                remain_dec;
  rfb_pkg::entry_t           entry;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // frame length check
  assign flen = {1'b0, payload_length_i} + {1'b0, rfb_pkg::FRAME_OVERHEAD};
  assign too_long = flen > rfb_pkg::FLEN_W'(MAX_FRAME_BYTES);
  assign remain_dec = remain_q - 8'd1;

  // classify the item
  always_comb begin
    entry          = '0;
    entry.status   = rfb_pkg::STATUS_OK;
    open_d         = open_q;
    remain_d       = remain_q;
    unique case (rfb_pkg::cmd_e'(command_i))
      rfb_pkg::CMD_START: begin
        entry.restart = 1'b1;
        if (too_long) begin
          entry.is_err = 1'b1;
          entry.status = rfb_pkg::STATUS_TOO_LONG;
          open_d       = 1'b0;
          remain_d     = '0;
        end else begin
          entry.n_data   = 3'(rfb_pkg::HDR_BYTES);
          entry.add_crc  = (payload_length_i == 8'd0);
          entry.bytes[0] = start_marker_i;
          entry.bytes[1] = address_one_i;
          entry.bytes[2] = address_two_i;
          entry.bytes[3] = frame_command_i;
          entry.bytes[4] = frame_subcommand_i;
          entry.bytes[5] = flen[7:0];
          open_d         = (payload_length_i != 8'd0);
          remain_d       = payload_length_i;
        end
      end
      rfb_pkg::CMD_PAYLOAD: begin
        if (open_q) begin
          entry.n_data   = 3'd1;
          entry.add_crc  = (remain_dec == 8'd0);
          entry.bytes[0] = payload_byte_i;
          remain_d       = remain_dec;
          open_d         = (remain_dec != 8'd0);
        end else begin
          entry.is_err = 1'b1;
          entry.status = rfb_pkg::STATUS_NO_FRAME;
        end
      end
      default: begin
        entry.is_err = 1'b1;
        entry.status = rfb_pkg::STATUS_NO_FRAME;
      end
    endcase
  end

  assign push_o.valid = accept;
  assign push_o.entry = entry;

  // frame tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      remain_q <= '0;
    end else if (accept) begin
      open_q   <= open_d;
      remain_q <= remain_d;
    end
  end

  // an open frame always has bytes still expected
  a_open_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> remain_q != 8'd0)
    else $error("open frame with no bytes remaining");

endmodule

### rtl/core/rfb_queue.sv
// short queue of classified operations between front and back
module rfb_queue #(
  parameter int unsigned DEPTH = rfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rfb_pkg::push_t  push_i,
  input  logic            pop_i,
  output rfb_pkg::entry_t entry_o,
  output rfb_pkg::qstat_t qstat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rfb_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push = push_i.valid && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // fill count never goes past the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue fill count past depth");

endmodule

### rtl/core/rfb_back.sv
// back end: serializes queued operations into frame bytes and runs the crc
module rfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rfb_pkg::entry_t entry_i,
  input  rfb_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o,
  output logic [1:0]      status_o
);

  // one byte into a reflected crc-16, bit at a time
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ rfb_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0] crc_q, crc_d;
  logic [2:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        end_q, end_d;
  logic [1:0]  status_q, status_d;
  logic        can_load, load;
  logic        data_ph, crc_lo, crc_hi, last_step;
  logic [7:0]  data_byte;
  logic [15:0] crc_base;

  assign can_load = !out_valid_q || !out_stall_i;
  assign load     = !qstat_i.empty && can_load;

  // step decode for the current operation
  assign data_ph   = !entry_i.is_err && (step_q < entry_i.n_data);
  assign crc_lo    = !entry_i.is_err && entry_i.add_crc && (step_q == entry_i.n_data);
  assign crc_hi    = !entry_i.is_err && entry_i.add_crc &&
                     (step_q == entry_i.n_data + 3'd1);
  assign last_step = entry_i.is_err ||
                     (entry_i.add_crc ? crc_hi : (step_q == entry_i.n_data - 3'd1));
  assign data_byte = entry_i.bytes[step_q];
  assign crc_base  = (entry_i.restart && step_q == 3'd0) ? rfb_pkg::CRC_INIT : crc_q;
  assign pop_o     = load && last_step;

  // result byte and next crc
  always_comb begin
    crc_d    = crc_q;
    byte_d   = byte_q;
    end_d    = end_q;
    status_d = status_q;
    step_d   = step_q;
    if (load) begin
      step_d   = last_step ? 3'd0 : step_q + 3'd1;
      status_d = entry_i.status;
      end_d    = entry_i.is_err || crc_hi;
      priority if (entry_i.is_err) begin
        byte_d = 8'h00;
        if (entry_i.restart) begin
          crc_d = rfb_pkg::CRC_INIT;
        end
      end else if (data_ph) begin
        byte_d = data_byte;
        crc_d  = crc_feed(crc_base, data_byte);
      end else if (crc_lo) begin
        byte_d = crc_q[7:0];
      end else begin
        byte_d = crc_q[15:8];
        crc_d  = rfb_pkg::CRC_INIT;
      end
    end
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  // control and crc state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= rfb_pkg::CRC_INIT;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    end_q    <= end_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign frame_end_o = end_q;
  assign status_o    = status_q;

  // an error result is a lone zero byte that ends the frame
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != rfb_pkg::STATUS_OK |-> end_q && byte_q == 8'h00)
    else $error("malformed error result");

  // crc restarts after the final crc byte
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && crc_hi |=> crc_q == rfb_pkg::CRC_INIT)
    else $error("crc not restarted after frame");

  // step counter stays within one header plus crc
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat_i.empty && !entry_i.is_err |-> step_q <= entry_i.n_data + 3'd1)
    else $error("step counter out of range");

endmodule

### rtl/core/rs485_frame_builder_crc16.sv
// top level of the rs485 frame builder with crc-16 trailer
//
//  channel  dir  handshake                 payload
//  in       in   in_valid_i / in_stall_o   command_i, header fields, payload_byte_i
//  out      out  out_valid_o / out_stall_i out_byte_o, frame_end_o, status_o
//
// one result byte per cycle from the back end while an op is queued and out_stall_i
// is low; a payload item gives one byte, the last one adds two crc bytes, a start
// item six, or eight with zero payload length, an error one zero byte. the back
// end has a single output register; the crc folds one byte per cycle as bytes load.
// the front end accepts one item per cycle while the queue has room. reset clears
// frame tracking, queue pointers, the crc and output valid; no clearing pass.
// out_stall_i holds the output register and, once the queue fills, sets in_stall_o.
module rs485_frame_builder_crc16 #(
  parameter int unsigned MAX_FRAME_BYTES = rfb_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = rfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] start_marker_i,
  input  logic [7:0] address_one_i,
  input  logic [7:0] address_two_i,
  input  logic [7:0] frame_command_i,
  input  logic [7:0] frame_subcommand_i,
  input  logic [7:0] payload_length_i,
  input  logic [7:0] payload_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic [1:0] status_o
);

  rfb_pkg::push_t  push;
  rfb_pkg::qstat_t qstat;
  rfb_pkg::entry_t head;
  logic            pop;

  // classify incoming items
  rfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .start_marker_i    (start_marker_i),
    .address_one_i     (address_one_i),
    .address_two_i     (address_two_i),
    .frame_command_i   (frame_command_i),
    .frame_subcommand_i(frame_subcommand_i),
    .payload_length_i  (payload_length_i),
    .payload_byte_i    (payload_byte_i),
    .qstat_i           (qstat),
    .push_o            (push)
  );

  // decouple front and back
  rfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .entry_o(head),
    .qstat_o(qstat)
  );

  // serialize and append crc
  rfb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .frame_end_o(frame_end_o),
    .status_o   (status_o)
  );

endmodule
